FILE: src/bts_pkg.sv
`timescale 1ns / 1ps

package bts_pkg;

  // size registers and coordinate widths
  localparam int SZ_W   = 8;
  localparam int POS_W  = 16;
  localparam int REM_W  = 15;
  localparam int CH_W   = 16;
  localparam int RGB_W  = 3 * CH_W;
  localparam int IDX_W  = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_BORDER_MODE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_FILTER_MODE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_EXPOSURE     = 3'd4;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic BORDER_CLAMP  = 1'b0;
  localparam logic FILTER_LINEAR = 1'b1;

  // memory request from the coordinate pipe
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_req_t;

  // four restoring steps of rem mod size, shifts hi down to hi-3
  function automatic logic [REM_W-1:0] mod_part(input logic [REM_W-1:0] rem,
                                                input logic [SZ_W-1:0] size,
                                                input int hi);
    logic [REM_W+SZ_W-1:0] r;
    logic [REM_W+SZ_W-1:0] d;
    int k;
    r = {{SZ_W{1'b0}}, rem};
    for (int j = 0; j < 4; j++) begin
      k = hi - j;
      if (k >= 0) begin
        d = (REM_W + SZ_W)'(size) << k;
        if (r >= d) r = r - d;
      end
    end
    return r[REM_W-1:0];
  endfunction

  function automatic logic [SZ_W-1:0] clamp_pos(input logic signed [POS_W-1:0] pos,
                                                 input logic [SZ_W-1:0] size);
    logic [SZ_W-1:0] res;
    if (pos < 0) begin
      res = '0;
    end else if (pos >= $signed({{(POS_W-SZ_W){1'b0}}, size})) begin
      res = size - 1'b1;
    end else begin
      res = pos[SZ_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: src/bilinear_texture_sampler.sv
`timescale 1ns / 1ps

// Channel   | Handshake              | Payload
// ----------+------------------------+------------------------------------------
// item in   | start, busy            | op, u, v, texel_x/y, texel_red/green/blue
// result    | done (one cycle)       | red, green, blue
// config    | cfg_write              | cfg_index, cfg_data
//
// A texel write does not raise busy; a sample holds busy so that the four reads it
// makes of the single-port texel RAM do not meet the access of the next item.
// rst is synchronous; the texel RAM is not cleared and must be written first.
// The receiver cannot stall; done marks each result for one cycle.

module bilinear_texture_sampler #(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 128,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic signed [20:0]            u,
  input  logic signed [20:0]            v,
  input  logic [6:0]                    texel_x,
  input  logic [6:0]                    texel_y,
  input  logic [15:0]                   texel_red,
  input  logic [15:0]                   texel_green,
  input  logic [15:0]                   texel_blue,
  output logic [15:0]                   red,
  output logic [15:0]                   green,
  output logic [15:0]                   blue,
  output logic                          done,
  input  logic                          cfg_write,
  input  logic [bts_pkg::IDX_W-1:0]     cfg_index,
  input  logic [15:0]                   cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SZ_W  = bts_pkg::SZ_W;

  logic [SZ_W-1:0] image_width, image_height;
  logic            border_mode, filter_mode;
  logic [15:0]     exposure;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 8'd128;
      image_height <= 8'd128;
      border_mode  <= 1'b1;
      filter_mode  <= 1'b1;
      exposure     <= 16'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        bts_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[SZ_W-1:0];
        bts_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[SZ_W-1:0];
        bts_pkg::REG_BORDER_MODE:  border_mode  <= cfg_data[0];
        bts_pkg::REG_FILTER_MODE:  filter_mode  <= cfg_data[0];
        bts_pkg::REG_EXPOSURE:     exposure     <= cfg_data;
        default: ;
      endcase
    end
  end

  // size in use: zero reads as one, capped at the store size
  logic [SZ_W-1:0] w_eff, h_eff;

  assign w_eff = (image_width == '0) ? SZ_W'(1)
               : (32'(image_width) > MAX_WIDTH) ? SZ_W'(MAX_WIDTH) : image_width;
  assign h_eff = (image_height == '0) ? SZ_W'(1)
               : (32'(image_height) > MAX_HEIGHT) ? SZ_W'(MAX_HEIGHT) : image_height;

  logic       take;
  logic [1:0] hold_cnt;

  assign take = start && !busy;
  assign busy = (hold_cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 2'd0;
    end else if (take && op == bts_pkg::OP_SAMPLE) begin
      hold_cnt <= 2'd3;
    end else if (hold_cnt != 2'd0) begin
      hold_cnt <= hold_cnt - 2'd1;
    end
  end

  bts_pkg::mem_req_t          ctl;
  logic [3:0][AW-1:0]         addr;
  logic [bts_pkg::RGB_W-1:0]  wdata;
  logic [WEIGHT_BITS-1:0]     wx, wy;
  logic                       ram_we;
  logic [AW-1:0]              ram_addr;
  logic [bts_pkg::RGB_W-1:0]  ram_wdata, ram_rdata;

  bts_coord #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .WEIGHT_BITS (WEIGHT_BITS),
    .AW          (AW)
  ) u_coord (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .op          (op),
    .u           (u),
    .v           (v),
    .texel_x     (texel_x),
    .texel_y     (texel_y),
    .texel_rgb   ({texel_red, texel_green, texel_blue}),
    .width       (w_eff),
    .height      (h_eff),
    .border_mode (border_mode),
    .filter_mode (filter_mode),
    .ctl         (ctl),
    .addr        (addr),
    .wdata       (wdata),
    .wx          (wx),
    .wy          (wy)
  );

  bts_ram #(
    .WIDTH (bts_pkg::RGB_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bts_filter #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .AW          (AW)
  ) u_filter (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .addr      (addr),
    .wdata     (wdata),
    .wx        (wx),
    .wy        (wy),
    .exposure  (exposure),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .done      (done)
  );

endmodule

FILE: src/bts_ram.sv
`timescale 1ns / 1ps

module bts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: src/bts_coord.sv
`timescale 1ns / 1ps

module bts_coord #(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 128,
  parameter int WEIGHT_BITS = 8,
  parameter int AW          = 14
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  logic                             op,
  input  logic signed [20:0]               u,
  input  logic signed [20:0]               v,
  input  logic [6:0]                       texel_x,
  input  logic [6:0]                       texel_y,
  input  logic [bts_pkg::RGB_W-1:0]        texel_rgb,
  input  logic [bts_pkg::SZ_W-1:0]         width,
  input  logic [bts_pkg::SZ_W-1:0]         height,
  input  logic                             border_mode,
  input  logic                             filter_mode,
  output bts_pkg::mem_req_t                ctl,
  output logic [3:0][AW-1:0]               addr,
  output logic [bts_pkg::RGB_W-1:0]        wdata,
  output logic [WEIGHT_BITS-1:0]           wx,
  output logic [WEIGHT_BITS-1:0]           wy
);

  localparam int SZ_W  = bts_pkg::SZ_W;
  localparam int POS_W = bts_pkg::POS_W;
  localparam int REM_W = bts_pkg::REM_W;
  localparam logic [AW-1:0] ROW = AW'(MAX_WIDTH);

  typedef struct packed {
    logic                        rd;
    logic                        wr;
    logic [6:0]                  tx;
    logic [6:0]                  ty;
    logic [bts_pkg::RGB_W-1:0]   rgb;
    logic signed [POS_W-1:0]     posx;
    logic signed [POS_W-1:0]     posy;
    logic [15:0]                 fx;
    logic [15:0]                 fy;
    logic [REM_W-1:0]            remx;
    logic [REM_W-1:0]            remy;
    logic                        negx;
    logic                        negy;
  } stage_t;

  function automatic logic [AW-1:0] texel_addr(input logic [SZ_W-1:0] x,
                                               input logic [SZ_W-1:0] y);
    return AW'(y) * ROW + AW'(x);
  endfunction

  // product stage
  logic                      p_rd, p_wr, p_bil;
  logic [6:0]                p_tx, p_ty;
  logic [bts_pkg::RGB_W-1:0] p_rgb;
  logic signed [29:0]        p_xp;
  logic signed [31:0]        p_yp;
  logic signed [22:0]        vd;
  logic                      fits;

  assign vd   = 23'sd65536 - 23'(v);
  assign fits = (32'(texel_x) < MAX_WIDTH) && (32'(texel_y) < MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_rd <= 1'b0;
      p_wr <= 1'b0;
    end else begin
      p_rd <= take && (op == bts_pkg::OP_SAMPLE);
      p_wr <= take && (op == bts_pkg::OP_WRITE) && fits;
    end
    p_bil <= (filter_mode == bts_pkg::FILTER_LINEAR);
    p_tx  <= texel_x;
    p_ty  <= texel_y;
    p_rgb <= texel_rgb;
    p_xp  <= 30'(u) * 30'($signed({1'b0, width}));
    p_yp  <= 32'(vd) * 32'($signed({1'b0, height}));
  end

  // texel space: x = u*w - 0.5; nearest rounds, which cancels the half
  logic signed [32:0] xq, yq;
  logic signed [POS_W-1:0] px, py, nx, ny;

  assign xq = p_bil ? 33'(p_xp) - 33'sd32768 : 33'(p_xp);
  assign yq = p_bil ? 33'(p_yp) - 33'sd32768 : 33'(p_yp);
  assign px = xq[31:16];
  assign py = yq[31:16];
  assign nx = -px;
  assign ny = -py;

  stage_t st [1:5];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 5; i++) begin
        st[i].rd <= 1'b0;
        st[i].wr <= 1'b0;
      end
    end else begin
      st[1].rd <= p_rd;
      st[1].wr <= p_wr;
      for (int i = 2; i <= 5; i++) begin
        st[i].rd <= st[i-1].rd;
        st[i].wr <= st[i-1].wr;
      end
    end
    st[1].tx   <= p_tx;
    st[1].ty   <= p_ty;
    st[1].rgb  <= p_rgb;
    st[1].posx <= px;
    st[1].posy <= py;
    // nearest: zero weights select the first texel alone
    st[1].fx   <= p_bil ? xq[15:0] : 16'd0;
    st[1].fy   <= p_bil ? yq[15:0] : 16'd0;
    st[1].negx <= px[POS_W-1];
    st[1].negy <= py[POS_W-1];
    st[1].remx <= px[POS_W-1] ? nx[REM_W-1:0] : px[REM_W-1:0];
    st[1].remy <= py[POS_W-1] ? ny[REM_W-1:0] : py[REM_W-1:0];
    // repeat addressing: |pos| mod size, four steps a stage
    for (int i = 2; i <= 5; i++) begin
      st[i].tx   <= st[i-1].tx;
      st[i].ty   <= st[i-1].ty;
      st[i].rgb  <= st[i-1].rgb;
      st[i].posx <= st[i-1].posx;
      st[i].posy <= st[i-1].posy;
      st[i].fx   <= st[i-1].fx;
      st[i].fy   <= st[i-1].fy;
      st[i].negx <= st[i-1].negx;
      st[i].negy <= st[i-1].negy;
      st[i].remx <= bts_pkg::mod_part(st[i-1].remx, width, 14 - 4 * (i - 2));
      st[i].remy <= bts_pkg::mod_part(st[i-1].remy, height, 14 - 4 * (i - 2));
    end
  end

  // border addressing of floor and floor+1
  logic [SZ_W-1:0] rx, ry, x0, x1, y0, y1;
  logic [SZ_W-1:0] rx1, ry1;
  logic signed [POS_W-1:0] px1, py1;

  always_comb begin
    rx  = (st[5].negx && st[5].remx != '0) ? width - st[5].remx[SZ_W-1:0]
                                           : st[5].remx[SZ_W-1:0];
    ry  = (st[5].negy && st[5].remy != '0) ? height - st[5].remy[SZ_W-1:0]
                                           : st[5].remy[SZ_W-1:0];
    rx1 = ({1'b0, rx} + 9'd1 == {1'b0, width}) ? '0 : rx + 1'b1;
    ry1 = ({1'b0, ry} + 9'd1 == {1'b0, height}) ? '0 : ry + 1'b1;
    px1 = st[5].posx + 16'sd1;
    py1 = st[5].posy + 16'sd1;
    if (border_mode == bts_pkg::BORDER_CLAMP) begin
      x0 = bts_pkg::clamp_pos(st[5].posx, width);
      x1 = bts_pkg::clamp_pos(px1, width);
      y0 = bts_pkg::clamp_pos(st[5].posy, height);
      y1 = bts_pkg::clamp_pos(py1, height);
    end else begin
      x0 = rx;
      x1 = rx1;
      y0 = ry;
      y1 = ry1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.rd <= st[5].rd;
      ctl.wr <= st[5].wr;
    end
    addr[0] <= st[5].wr ? AW'(st[5].ty) * ROW + AW'(st[5].tx) : texel_addr(x0, y0);
    addr[1] <= texel_addr(x1, y0);
    addr[2] <= texel_addr(x0, y1);
    addr[3] <= texel_addr(x1, y1);
    wdata   <= st[5].rgb;
    wx      <= st[5].fx[15 -: WEIGHT_BITS];
    wy      <= st[5].fy[15 -: WEIGHT_BITS];
  end

endmodule

FILE: src/bts_filter.sv
`timescale 1ns / 1ps

module bts_filter #(
  parameter int WEIGHT_BITS = 8,
  parameter int AW          = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bts_pkg::mem_req_t           ctl,
  input  logic [3:0][AW-1:0]          addr,
  input  logic [bts_pkg::RGB_W-1:0]   wdata,
  input  logic [WEIGHT_BITS-1:0]      wx,
  input  logic [WEIGHT_BITS-1:0]      wy,
  input  logic [15:0]                 exposure,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_addr,
  output logic [bts_pkg::RGB_W-1:0]   ram_wdata,
  input  logic [bts_pkg::RGB_W-1:0]   ram_rdata,
  output logic [15:0]                 red,
  output logic [15:0]                 green,
  output logic [15:0]                 blue,
  output logic                        done
);

  localparam int CH_W = bts_pkg::CH_W;
  localparam int WB   = WEIGHT_BITS;
  localparam int RW   = CH_W + WB + 1;
  localparam int FW   = CH_W + 2 * WB + 2;
  localparam int PW   = FW + 16;
  localparam int SH   = 2 * WB + 8;
  localparam logic [WB:0] ONE = (WB + 1)'(1) << WB;

  // read sequencer: four reads per sample, one per cycle
  logic [1:0]          ph;
  logic [AW-1:0]       hold [1:3];
  logic [WB-1:0]       wxh, wyh;
  logic                iss;
  logic [1:0]          iss_idx;
  logic                dval;
  logic [1:0]          didx;

  assign iss     = ctl.rd || (ph != 2'd0);
  assign iss_idx = ctl.rd ? 2'd0 : ph;

  always_comb begin
    ram_we    = ctl.wr;
    ram_wdata = wdata;
    if (ctl.rd || ctl.wr) begin
      ram_addr = addr[0];
    end else if (ph != 2'd0) begin
      ram_addr = hold[ph];
    end else begin
      ram_addr = addr[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= 2'd0;
      dval <= 1'b0;
    end else begin
      if (ctl.rd) begin
        ph <= 2'd1;
      end else if (ph != 2'd0) begin
        ph <= (ph == 2'd3) ? 2'd0 : ph + 2'd1;
      end
      dval <= iss;
    end
    didx <= iss_idx;
    if (ctl.rd) begin
      hold[1] <= addr[1];
      hold[2] <= addr[2];
      hold[3] <= addr[3];
      wxh     <= wx;
      wyh     <= wy;
    end
  end

  // blend: row pairs as texels arrive, then columns, then exposure
  logic [WB:0]        omwx, omwy;
  logic [CH_W-1:0]    tin [3];
  logic [CH_W-1:0]    t00 [3];
  logic [CH_W-1:0]    t01 [3];
  logic [RW-1:0]      r0 [3];
  logic [RW-1:0]      r1 [3];
  logic [RW-1:0]      rmix [3];
  logic [WB-1:0]      wy1;
  logic               go1, go2, go3;
  logic [FW-1:0]      full [3];
  logic [PW-1:0]      prod [3];
  logic [PW-1:0]      shd [3];
  logic [CH_W-1:0]    res [3];

  assign omwx = ONE - {1'b0, wxh};
  assign omwy = ONE - {1'b0, wy1};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tin[c]  = ram_rdata[(2 - c) * CH_W +: CH_W];
      rmix[c] = RW'(tin[c]) * RW'(wxh)
              + RW'((didx == 2'd1) ? t00[c] : t01[c]) * RW'(omwx);
      shd[c]  = prod[c] >> SH;
      res[c]  = (|shd[c][PW-1:CH_W]) ? {CH_W{1'b1}} : shd[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      go1  <= 1'b0;
      go2  <= 1'b0;
      go3  <= 1'b0;
      done <= 1'b0;
    end else begin
      go1  <= dval && (didx == 2'd3);
      go2  <= go1;
      go3  <= go2;
      done <= go3;
    end
    for (int c = 0; c < 3; c++) begin
      if (dval && didx == 2'd0) t00[c] <= tin[c];
      if (dval && didx == 2'd2) t01[c] <= tin[c];
      if (dval && didx == 2'd1) r0[c] <= rmix[c];
      if (dval && didx == 2'd3) r1[c] <= rmix[c];
      full[c] <= FW'(r1[c]) * FW'(wy1) + FW'(r0[c]) * FW'(omwy);
      prod[c] <= PW'(full[c]) * PW'(exposure);
    end
    if (dval && didx == 2'd3) wy1 <= wyh;
    red   <= res[0];
    green <= res[1];
    blue  <= res[2];
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic               op;
    logic signed [20:0] u;
    logic signed [20:0] v;
    logic [6:0]         tx;
    logic [6:0]         ty;
    logic [15:0]        r;
    logic [15:0]        g;
    logic [15:0]        b;
  } tex_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic op = bts_pkg::OP_WRITE;
  logic signed [20:0] u = '0;
  logic signed [20:0] v = '0;
  logic [6:0] texel_x = '0;
  logic [6:0] texel_y = '0;
  logic [15:0] texel_red = '0;
  logic [15:0] texel_green = '0;
  logic [15:0] texel_blue = '0;
  logic [15:0] red, green, blue;
  logic done;
  logic cfg_write = 1'b0;
  logic [bts_pkg::IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bilinear_texture_sampler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .u(u), .v(v),
    .texel_x(texel_x), .texel_y(texel_y), .texel_red(texel_red),
    .texel_green(texel_green), .texel_blue(texel_blue), .red(red), .green(green),
    .blue(blue), .done(done), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the block's state
  logic [47:0] texel_mem [16384];
  logic [7:0]  img_w, img_h;
  logic        border_sel, filter_sel;
  logic [15:0] expo;

  tex_item_t   pending_items[$];
  logic [47:0] expected_rgb[$];
  int          idle_pct = 0;
  int          errors = 0;
  int          n_samples = 0, n_writes = 0;

  function automatic longint wrap_axis(longint p, longint size);
    longint r;
    if (border_sel == bts_pkg::BORDER_CLAMP) begin
      if (p < 0) return 0;
      if (p > size - 1) return size - 1;
      return p;
    end
    r = p % size;
    if (r < 0) r += size;
    return r;
  endfunction

  function automatic logic [47:0] texel_at(longint px, longint py, longint w, longint h);
    longint cx, cy;
    cx = wrap_axis(px, w);
    cy = wrap_axis(py, h);
    return texel_mem[cy * 128 + cx];
  endfunction

  function automatic logic [15:0] scale_sat(longint unsigned full, int shift);
    longint unsigned s;
    s = (full * expo) >> shift;
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [47:0] sample_color(logic signed [20:0] su, logic signed [20:0] sv);
    longint w, h, xq, yq, fx, fy, wx, wy, x0, y0;
    longint unsigned c00, c10, c01, c11, r0, r1, full;
    logic [47:0] t00, t10, t01, t11, res;
    w = (img_w == 0) ? 1 : img_w;
    h = (img_h == 0) ? 1 : img_h;
    if (w > 128) w = 128;
    if (h > 128) h = 128;
    xq = longint'(su) * w - 32768;
    yq = (65536 - longint'(sv)) * h - 32768;
    if (filter_sel != bts_pkg::FILTER_LINEAR) begin
      x0 = (xq + 32768) >>> 16;
      y0 = (yq + 32768) >>> 16;
      t00 = texel_at(x0, y0, w, h);
      for (int ch = 0; ch < 3; ch++)
        res[ch*16 +: 16] = scale_sat(t00[ch*16 +: 16], 8);
    end else begin
      fx = xq >>> 16;
      fy = yq >>> 16;
      wx = (xq - fx * 65536) >> 8;
      wy = (yq - fy * 65536) >> 8;
      t00 = texel_at(fx, fy, w, h);
      t10 = texel_at(fx + 1, fy, w, h);
      t01 = texel_at(fx, fy + 1, w, h);
      t11 = texel_at(fx + 1, fy + 1, w, h);
      for (int ch = 0; ch < 3; ch++) begin
        c00 = t00[ch*16 +: 16];
        c10 = t10[ch*16 +: 16];
        c01 = t01[ch*16 +: 16];
        c11 = t11[ch*16 +: 16];
        r0 = c10 * wx + c00 * (256 - wx);
        r1 = c11 * wx + c01 * (256 - wx);
        full = r1 * wy + r0 * (256 - wy);
        res[ch*16 +: 16] = scale_sat(full, 24);
      end
    end
    return res;
  endfunction

  // driver: channel order in the shadow word is {blue, green, red}
  tex_item_t cur;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cur.op == bts_pkg::OP_WRITE) begin
          texel_mem[cur.ty * 128 + cur.tx] = {cur.b, cur.g, cur.r};
          n_writes++;
        end else begin
          expected_rgb.push_back(sample_color(cur.u, cur.v));
          n_samples++;
        end
      end
      if (!start || !busy) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur = pending_items.pop_front();
          start <= 1'b1;
          op <= cur.op;
          u <= cur.u;
          v <= cur.v;
          texel_x <= cur.tx;
          texel_y <= cur.ty;
          texel_red <= cur.r;
          texel_green <= cur.g;
          texel_blue <= cur.b;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [47:0] want;
    if (!rst && done) begin
      if (expected_rgb.size() == 0) begin
        $display("%0t: unexpected result %h %h %h", $time, red, green, blue);
        errors++;
      end else begin
        want = expected_rgb.pop_front();
        if (red !== want[15:0]) begin
          $display("%0t: red expected %h actual %h", $time, want[15:0], red);
          errors++;
        end
        if (green !== want[31:16]) begin
          $display("%0t: green expected %h actual %h", $time, want[31:16], green);
          errors++;
        end
        if (blue !== want[47:32]) begin
          $display("%0t: blue expected %h actual %h", $time, want[47:32], blue);
          errors++;
        end
      end
    end
  end

  function automatic tex_item_t texel_write(int x, int y, logic [15:0] r, logic [15:0] g,
                                            logic [15:0] b);
    tex_item_t it;
    it.op = bts_pkg::OP_WRITE;
    it.u = 21'($urandom);
    it.v = 21'($urandom);
    it.tx = 7'(x);
    it.ty = 7'(y);
    it.r = r;
    it.g = g;
    it.b = b;
    return it;
  endfunction

  function automatic tex_item_t sample_at(logic signed [20:0] su, logic signed [20:0] sv);
    tex_item_t it;
    it = texel_write($urandom_range(127), $urandom_range(127), 16'($urandom), 16'($urandom),
                     16'($urandom));
    it.op = bts_pkg::OP_SAMPLE;
    it.u = su;
    it.v = sv;
    return it;
  endfunction

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [20:0] rand_coord();
    if ($urandom_range(9) == 0) return 21'($urandom);
    return 21'(int'($urandom_range(4 * 65536)) - 2 * 65536);
  endfunction

  // waits for every item to be sent and every expected result to arrive, then lets the pipe empty
  task automatic drain();
    while (pending_items.size() > 0 || start || expected_rgb.size() > 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(logic [bts_pkg::IDX_W-1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      bts_pkg::REG_IMAGE_WIDTH:  img_w = data[7:0];
      bts_pkg::REG_IMAGE_HEIGHT: img_h = data[7:0];
      bts_pkg::REG_BORDER_MODE:  border_sel = data[0];
      bts_pkg::REG_FILTER_MODE:  filter_sel = data[0];
      bts_pkg::REG_EXPOSURE:     expo = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_all(logic [7:0] w, logic [7:0] h, logic bm, logic fm, logic [15:0] ex);
    write_reg(bts_pkg::REG_IMAGE_WIDTH, {8'($urandom), w});
    write_reg(bts_pkg::REG_IMAGE_HEIGHT, {8'($urandom), h});
    write_reg(bts_pkg::REG_BORDER_MODE, {15'($urandom), bm});
    write_reg(bts_pkg::REG_FILTER_MODE, {15'($urandom), fm});
    write_reg(bts_pkg::REG_EXPOSURE, ex);
  endtask

  function automatic logic [7:0] rand_size();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd128;
      2: return 8'($urandom_range(255, 129));
      default: return 8'($urandom_range(16, 1));
    endcase
  endfunction

  initial begin
    logic [7:0] rw, rh;
    int         mode;
    img_w = 128;
    img_h = 128;
    border_sel = 1'b1;
    filter_sel = 1'b1;
    expo = 16'd256;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // loaded: row 0, column 0 and a 16x16 corner; every image in use stays inside
    for (int x = 0; x < 128; x++)
      pending_items.push_back(texel_write(x, 0, rand_chan(), rand_chan(), rand_chan()));
    for (int y = 1; y < 128; y++)
      pending_items.push_back(texel_write(0, y, rand_chan(), rand_chan(), rand_chan()));
    for (int y = 1; y < 16; y++)
      for (int x = 1; x < 16; x++)
        pending_items.push_back(texel_write(x, y, rand_chan(), rand_chan(), rand_chan()));
    drain();

    // directed: reset modes and exposure, coordinate extremes, exact texel centers
    write_reg(bts_pkg::REG_IMAGE_WIDTH, 16'd16);
    write_reg(bts_pkg::REG_IMAGE_HEIGHT, 16'd16);
    pending_items.push_back(sample_at(21'sh100000, 21'sh100000));
    pending_items.push_back(sample_at(21'sh0FFFFF, 21'sh0FFFFF));
    pending_items.push_back(sample_at(21'sd0, 21'sd0));
    pending_items.push_back(sample_at(21'sd2048, 21'sd63488));
    pending_items.push_back(texel_write(15, 15, 16'hFFFF, 16'h0000, 16'hFFFF));
    pending_items.push_back(texel_write(0, 0, 16'h0000, 16'hFFFF, 16'h0000));
    pending_items.push_back(sample_at(21'sd65535, 21'sd1));
    drain();
    set_all(8'd0, 8'd0, bts_pkg::BORDER_CLAMP, ~bts_pkg::FILTER_LINEAR, 16'd0);
    write_reg(3'd5, 16'hFFFF);  // unused index
    write_reg(3'd7, 16'h1234);
    pending_items.push_back(sample_at(21'sh100000, 21'sh0FFFFF));
    pending_items.push_back(sample_at(21'sd32768, 21'sd32768));
    drain();
    set_all(8'd255, 8'd1, 1'b1, bts_pkg::FILTER_LINEAR, 16'hFFFF);
    pending_items.push_back(sample_at(21'sh0FFFFF, 21'sh100000));
    pending_items.push_back(sample_at(21'sd12345, -21'sd54321));
    pending_items.push_back(sample_at(-21'sd1, 21'sd65536));
    drain();
    set_all(8'd1, 8'd128, bts_pkg::BORDER_CLAMP, bts_pkg::FILTER_LINEAR, 16'd256);
    pending_items.push_back(sample_at(-21'sd70000, 21'sd140000));
    pending_items.push_back(sample_at(21'sd98304, 21'sd16384));
    drain();
    set_all(8'd129, 8'd1, 1'b1, ~bts_pkg::FILTER_LINEAR, 16'd1);
    pending_items.push_back(sample_at(21'sh100000, 21'sh100000));
    pending_items.push_back(sample_at(21'sd40000, -21'sd40000));
    drain();

    // random phases: sender idles 22%, then 50%, then never
    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph < 3) ? 22 : (ph < 6) ? 50 : 0;
      mode = $urandom_range(3);
      if (mode == 0) begin
        rw = rand_size();
        rh = 8'($urandom_range(1));
      end else if (mode == 1) begin
        rw = 8'($urandom_range(1));
        rh = rand_size();
      end else begin
        rw = 8'($urandom_range(16));
        rh = 8'($urandom_range(16));
      end
      set_all(rw, rh, 1'($urandom_range(1)), 1'($urandom_range(1)),
              ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(512, 64)));
      for (int i = 0; i < 18; i++) begin
        if ($urandom_range(9) < 3)
          pending_items.push_back(texel_write($urandom_range(15), $urandom_range(15),
                                              rand_chan(), rand_chan(), rand_chan()));
        else
          pending_items.push_back(sample_at(rand_coord(), rand_coord()));
      end
      drain();
    end

    $display("covered %0d samples and %0d texel writes across clamp/repeat,", n_samples,
             n_writes);
    $display("nearest/bilinear, degenerate and oversized image sizes and exposure extremes");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout");
    $display("testbench: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
src/bts_pkg.sv
src/bts_ram.sv
src/bts_coord.sv
src/bts_filter.sv
src/bilinear_texture_sampler.sv
bench/testbench.sv
